@@ sv/hec_pkg.sv @@
// Package for the heater event controller.
// Holds the mode, event, fault and power codes, the snapshot and configuration structs
// and the reset values. It depends on nothing else.
package hec_pkg;

  typedef enum logic [2:0] {
    MODE_STANDBY = 3'd0,
    MODE_TIME    = 3'd1,
    MODE_POWER   = 3'd2,
    MODE_HEAT    = 3'd3,
    MODE_DONE    = 3'd4,
    MODE_FAULT   = 3'd5,
    MODE_UPDATE  = 3'd6
  } mode_t;

  localparam logic [3:0] OP_DOOR       = 4'd0;
  localparam logic [3:0] OP_START      = 4'd1;
  localparam logic [3:0] OP_SHORT      = 4'd2;
  localparam logic [3:0] OP_LONG       = 4'd3;
  localparam logic [3:0] OP_TICK       = 4'd4;
  localparam logic [3:0] OP_TEMP       = 4'd5;
  localparam logic [3:0] OP_SENSOR_ERR = 4'd6;
  localparam logic [3:0] OP_UPDATE     = 4'd7;
  localparam logic [3:0] OP_SYSFAULT   = 4'd8;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_OVERTEMP = 2'd1;
  localparam logic [1:0] FAULT_SENSOR   = 2'd2;
  localparam logic [1:0] FAULT_OVERFLOW = 2'd3;

  localparam logic [1:0] POWER_LOW  = 2'd0;
  localparam logic [1:0] POWER_MED  = 2'd1;
  localparam logic [1:0] POWER_HIGH = 2'd2;

  localparam logic [7:0] ERR_COUNT_MAX = 8'hFF;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SECS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERTEMP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRS  = 2'd3;

  localparam logic [11:0] RST_TIME_STEP = 12'd30;
  localparam logic [15:0] RST_MAX_SECS  = 16'd3600;
  localparam logic [7:0]  RST_OVERTEMP  = 8'd120;
  localparam logic [7:0]  RST_MAX_ERRS  = 8'd3;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  power;
    logic [1:0]  fault;
    logic [15:0] seconds;
    logic        door;
    logic        sensor_ok;
    logic        heater;
    logic [7:0]  temp;
    logic [7:0]  err_count;
  } snap_t;

  typedef struct packed {
    logic [11:0] time_step;
    logic [15:0] max_secs;
    logic [7:0]  overtemp;
    logic [7:0]  max_errs;
  } cfg_t;

  localparam snap_t SNAP_RESET = '{
    mode:      MODE_STANDBY,
    power:     POWER_MED,
    fault:     FAULT_NONE,
    seconds:   16'd0,
    door:      1'b0,
    sensor_ok: 1'b0,
    heater:    1'b0,
    temp:      8'd0,
    err_count: 8'd0
  };

endpackage

@@ sv/heater_event_controller_unit.sv @@
// Top level of the heater event controller.
// Instantiates hec_cfg_regs and hec_step and uses hec_pkg for types and codes.
//
// Each request on the input channel is one event (operation and value). For
// every event the block returns one request on the output channel carrying
// the full controller snapshot after the event and a flag that is set when
// any snapshot field differs from the snapshot before it.
// Both channels use valid and stall; a request moves on a rising edge with
// valid high and stall low. The configuration channel uses valid and ready,
// is always ready, and should only be written while no event is in flight.
// An accepted event is held in the input register. When the output register
// is free, the event is applied to the controller state and its result is
// registered in the output register at the same edge, where it is offered
// until taken. One event per cycle is sustained while the output is not
// stalled; the single update step between the two registers sets the rate.
// A stall on the output holds the result; the input register then fills and
// in_stall rises, so no event is lost. Reset empties both registers, returns
// the controller to standby at medium power and restores the default
// configuration.
module heater_event_controller_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [3:0]                    in_operation,
  input  logic [7:0]                    in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_mode,
  output logic [1:0]                    out_power_level,
  output logic [1:0]                    out_fault_code,
  output logic [15:0]                   out_seconds_left,
  output logic                          out_door_is_closed,
  output logic                          out_sensor_ok,
  output logic                          out_heater_on,
  output logic [7:0]                    out_temperature,
  output logic [7:0]                    out_error_count,
  output logic                          out_changed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  hec_pkg::cfg_t  cfg;
  hec_pkg::snap_t state_r;
  hec_pkg::snap_t state_nxt;
  hec_pkg::snap_t out_snap_r;
  logic           changed_nxt;
  logic           out_changed_r;
  logic           in_valid_r;
  logic [3:0]     in_op_r;
  logic [7:0]     in_val_r;
  logic           out_valid_r;
  logic           out_free;
  logic           advance;

  hec_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hec_step u_step (
    .cur     (state_r),
    .cfg     (cfg),
    .op      (in_op_r),
    .val     (in_val_r),
    .nxt     (state_nxt),
    .changed (changed_nxt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= hec_pkg::SNAP_RESET;
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (out_free) out_valid_r <= in_valid_r;
      if (advance) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op_r  <= in_operation;
      in_val_r <= in_value;
    end
    if (advance) begin
      out_snap_r    <= state_nxt;
      out_changed_r <= changed_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode           = out_snap_r.mode;
  assign out_power_level    = out_snap_r.power;
  assign out_fault_code     = out_snap_r.fault;
  assign out_seconds_left   = out_snap_r.seconds;
  assign out_door_is_closed = out_snap_r.door;
  assign out_sensor_ok      = out_snap_r.sensor_ok;
  assign out_heater_on      = out_snap_r.heater;
  assign out_temperature    = out_snap_r.temp;
  assign out_error_count    = out_snap_r.err_count;
  assign out_changed        = out_changed_r;

  // The heater is driven exactly while the controller is heating.
  a_heater_mode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.heater == (state_r.mode == hec_pkg::MODE_HEAT))
    else $error("heater flag and heating mode disagree");

  // The controller state moves only when an event is applied.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("state changed without an event");

  // An applied event always leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("event applied without a result");

  // The power setting never reaches the unused code.
  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.power != 2'd3)
    else $error("power level out of range");

endmodule

@@ sv/hec_cfg_regs.sv @@
// Configuration registers of the heater event controller.
// Uses hec_pkg for the register indexes, reset values and cfg_t.
module hec_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output hec_pkg::cfg_t                 cfg
);

  hec_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_step <= hec_pkg::RST_TIME_STEP;
      cfg_r.max_secs  <= hec_pkg::RST_MAX_SECS;
      cfg_r.overtemp  <= hec_pkg::RST_OVERTEMP;
      cfg_r.max_errs  <= hec_pkg::RST_MAX_ERRS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hec_pkg::CFG_TIME_STEP: cfg_r.time_step <= cfg_data[11:0];
        hec_pkg::CFG_MAX_SECS:  cfg_r.max_secs  <= cfg_data;
        hec_pkg::CFG_OVERTEMP:  cfg_r.overtemp  <= cfg_data[7:0];
        hec_pkg::CFG_MAX_ERRS:  cfg_r.max_errs  <= cfg_data[7:0];
      endcase
    end
  end

endmodule

@@ sv/hec_step.sv @@
// Next-state logic of the heater event controller for one event.
// Uses hec_pkg for the codes and the snapshot and configuration structs.
module hec_step (
  input  hec_pkg::snap_t cur,
  input  hec_pkg::cfg_t  cfg,
  input  logic [3:0]     op,
  input  logic [7:0]     val,
  output hec_pkg::snap_t nxt,
  output logic           changed
);

  logic [16:0] sum;
  logic [15:0] secs_dec;
  logic [7:0]  err_inc;

  always_comb begin
    nxt      = cur;
    sum      = {1'b0, cur.seconds} + {5'd0, cfg.time_step};
    secs_dec = (cur.seconds != 16'd0) ? cur.seconds - 16'd1 : cur.seconds;
    err_inc  = (cur.err_count != hec_pkg::ERR_COUNT_MAX) ? cur.err_count + 8'd1
                                                        : cur.err_count;
    unique case (op)
      hec_pkg::OP_DOOR: begin
        nxt.door = (val != 8'd0);
        if (val == 8'd0) begin
          nxt.heater = 1'b0;
          if (cur.mode == hec_pkg::MODE_HEAT) nxt.mode = hec_pkg::MODE_STANDBY;
        end
        if (cur.mode == hec_pkg::MODE_DONE) nxt.mode = hec_pkg::MODE_STANDBY;
      end
      hec_pkg::OP_START: begin
        if (cur.mode != hec_pkg::MODE_FAULT && cur.mode != hec_pkg::MODE_UPDATE &&
            cur.door && cur.sensor_ok && cur.fault == hec_pkg::FAULT_NONE &&
            cur.seconds != 16'd0) begin
          nxt.mode   = hec_pkg::MODE_HEAT;
          nxt.heater = 1'b1;
        end
      end
      hec_pkg::OP_SHORT: begin
        unique case (cur.mode)
          hec_pkg::MODE_STANDBY, hec_pkg::MODE_DONE: nxt.mode = hec_pkg::MODE_TIME;
          hec_pkg::MODE_TIME: begin
            nxt.seconds = (sum[15:0] > cfg.max_secs) ? 16'd0 : sum[15:0];
          end
          hec_pkg::MODE_POWER: begin
            unique case (cur.power)
              hec_pkg::POWER_LOW:  nxt.power = hec_pkg::POWER_MED;
              hec_pkg::POWER_MED:  nxt.power = hec_pkg::POWER_HIGH;
              hec_pkg::POWER_HIGH: nxt.power = hec_pkg::POWER_LOW;
              default:             nxt.power = hec_pkg::POWER_MED;
            endcase
          end
          default: ;
        endcase
      end
      hec_pkg::OP_LONG: begin
        if (cur.mode == hec_pkg::MODE_TIME) begin
          nxt.mode = hec_pkg::MODE_POWER;
        end else if (cur.mode == hec_pkg::MODE_POWER) begin
          nxt.mode = hec_pkg::MODE_TIME;
        end
      end
      hec_pkg::OP_TICK: begin
        if (cur.mode == hec_pkg::MODE_HEAT) begin
          nxt.seconds = secs_dec;
          if (secs_dec == 16'd0) begin
            nxt.heater = 1'b0;
            nxt.mode   = hec_pkg::MODE_DONE;
          end
        end
      end
      hec_pkg::OP_TEMP: begin
        nxt.temp      = val;
        nxt.err_count = 8'd0;
        nxt.sensor_ok = 1'b1;
        if (cur.mode == hec_pkg::MODE_HEAT && val >= cfg.overtemp) begin
          nxt.heater = 1'b0;
          nxt.fault  = hec_pkg::FAULT_OVERTEMP;
          nxt.mode   = hec_pkg::MODE_FAULT;
        end
      end
      hec_pkg::OP_SENSOR_ERR: begin
        nxt.err_count = err_inc;
        if (err_inc >= cfg.max_errs) begin
          nxt.sensor_ok = 1'b0;
          if (cur.mode == hec_pkg::MODE_HEAT) begin
            nxt.heater = 1'b0;
            nxt.fault  = hec_pkg::FAULT_SENSOR;
            nxt.mode   = hec_pkg::MODE_FAULT;
          end
        end
      end
      hec_pkg::OP_UPDATE: begin
        nxt.heater = 1'b0;
        nxt.mode   = hec_pkg::MODE_UPDATE;
      end
      hec_pkg::OP_SYSFAULT: begin
        nxt.heater = 1'b0;
        nxt.fault  = hec_pkg::FAULT_OVERFLOW;
        nxt.mode   = hec_pkg::MODE_FAULT;
      end
      default: ;
    endcase
    changed = (nxt != cur);
  end

endmodule
